### src/pcmn_pkg.sv
// ----------------------------------------------------------------------------
// pcmn_pkg: shared types and constants for the crop, mirror and normalize block
// Holds field widths, register and mean-source codes, the geometry bundle
// that travels from the register bank to the front and back parts, and the
// queue entry format.
// ----------------------------------------------------------------------------
package pcmn_pkg;

  localparam int MAX_SIDE     = 4096;
  localparam int MAX_CHANNELS = 4;
  localparam int QUEUE_DEPTH  = 4;

  localparam int SIDE_W  = $clog2(MAX_SIDE);   // counter / offset width
  localparam int SIZE_W  = SIDE_W + 1;         // size width, holds MAX_SIDE
  localparam int CHAN_W  = 2;
  localparam int PIXEL_W = 8;
  localparam int MEAN_W  = 16;
  localparam int IDX_W   = 26;
  localparam int VALUE_W = 32;
  localparam int SCALE_W = 20;
  localparam int MEANS_W = 64;
  localparam int DIFF_W  = PIXEL_W + 9;        // signed Q8.8 difference
  localparam int PROD_W  = DIFF_W + SCALE_W + 1;
  localparam int BASE_W  = CHAN_W + SIZE_W;    // c * oh + h
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_HEIGHT   = 3'd0,
    REG_SOURCE_WIDTH    = 3'd1,
    REG_CROP_SIDE       = 3'd2,
    REG_CROP_ROW_OFFSET = 3'd3,
    REG_CROP_COL_OFFSET = 3'd4,
    REG_MODE_FLAGS      = 3'd5,
    REG_CHANNEL_MEANS   = 3'd6,
    REG_SCALE_FACTOR    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MEAN_NONE    = 2'd0,
    MEAN_CHANNEL = 2'd1,
    MEAN_STREAM  = 2'd2
  } mean_src_t;

  // window geometry derived from the register bank
  typedef struct packed {
    logic [SIZE_W-1:0] hgt;
    logic [SIZE_W-1:0] wid;
    logic [SIZE_W-1:0] oh;
    logic [SIZE_W-1:0] ow;
    logic [SIDE_W-1:0] r0;
    logic [SIDE_W-1:0] c0;
    logic              mirror;
    mean_src_t         mean_sel;
  } geom_t;

  // one in-window pixel waiting for the back part
  typedef struct packed {
    logic [CHAN_W-1:0]        chan;
    logic [SIDE_W-1:0]        h;
    logic [SIDE_W-1:0]        w;
    logic signed [DIFF_W-1:0] diff;
  } entry_t;

  // clamp a size register into 1..MAX_SIDE
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_W'(MAX_SIDE)) r = SIZE_W'(MAX_SIDE);
    return r;
  endfunction

endpackage

### src/pcmn_if.sv
// ----------------------------------------------------------------------------
// pcmn_if: handshake channels of the crop, mirror and normalize block
// Pixel channel, result channel and register write channel, each with
// valid, ready and payload.
// ----------------------------------------------------------------------------
interface pcmn_pix_if;
  logic                          valid;
  logic                          ready;
  logic [pcmn_pkg::PIXEL_W-1:0]  pixel;
  logic [pcmn_pkg::MEAN_W-1:0]   mean_sample;
  logic                          start_of_image;
  modport source (output valid, pixel, mean_sample, start_of_image, input ready);
  modport sink   (input valid, pixel, mean_sample, start_of_image, output ready);
endinterface

interface pcmn_res_if;
  logic                          valid;
  logic                          ready;
  logic [pcmn_pkg::IDX_W-1:0]    dest_index;
  logic signed [pcmn_pkg::VALUE_W-1:0] value;
  modport source (output valid, dest_index, value, input ready);
  modport sink   (input valid, dest_index, value, output ready);
endinterface

interface pcmn_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pcmn_pkg::CFG_IDX_W-1:0]  index;
  logic [pcmn_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/pixel_crop_mirror_normalize.sv
// ----------------------------------------------------------------------------
// pixel_crop_mirror_normalize: crop, mirror and mean/scale normalize pixels
// Planar pixel stream in; one indexed, normalized result per in-window pixel.
// ----------------------------------------------------------------------------
// an accepted in-window pixel goes through the queue, the first back stage and the output register
// throughput: one pixel per cycle while the queue is not full; the front classifies in the accept cycle,
//   the back is a two-stage multiply pipeline ending in the output register
// a four-entry queue between front and back absorbs output stalls
// reset (rst, synchronous): position counters to zero, queue and pipeline
//   empty, registers to height 1, width 1, scale 1.0, all others zero
module pixel_crop_mirror_normalize (
  input  logic        clk,
  input  logic        rst,
  pcmn_pix_if.sink    pixels,
  pcmn_res_if.source  results,
  pcmn_cfg_if.sink    cfg
);

  // register bank
  logic [pcmn_pkg::SIZE_W-1:0]  source_height;
  logic [pcmn_pkg::SIZE_W-1:0]  source_width;
  logic [pcmn_pkg::SIZE_W-1:0]  crop_side;
  logic [pcmn_pkg::SIDE_W-1:0]  crop_row_offset;
  logic [pcmn_pkg::SIDE_W-1:0]  crop_col_offset;
  logic [2:0]                   mode_flags;
  logic [pcmn_pkg::MEANS_W-1:0] channel_means;
  logic [pcmn_pkg::SCALE_W-1:0] scale_factor;

  logic                         cfg_write;
  logic [pcmn_pkg::SIZE_W-1:0]  side;
  pcmn_pkg::geom_t              geom;

  // front to queue, queue to back
  logic                         push, pop, full, head_valid;
  pcmn_pkg::entry_t             push_entry, head;

  // register writes are always taken
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_height   <= pcmn_pkg::SIZE_W'(1);
      source_width    <= pcmn_pkg::SIZE_W'(1);
      crop_side       <= '0;
      crop_row_offset <= '0;
      crop_col_offset <= '0;
      mode_flags      <= '0;
      channel_means   <= '0;
      scale_factor    <= pcmn_pkg::SCALE_W'(65536);
    end else if (cfg_write) begin
      unique case (pcmn_pkg::cfg_reg_t'(cfg.index))
        pcmn_pkg::REG_SOURCE_HEIGHT:   source_height   <= cfg.data[pcmn_pkg::SIZE_W-1:0];
        pcmn_pkg::REG_SOURCE_WIDTH:    source_width    <= cfg.data[pcmn_pkg::SIZE_W-1:0];
        pcmn_pkg::REG_CROP_SIDE:       crop_side       <= cfg.data[pcmn_pkg::SIZE_W-1:0];
        pcmn_pkg::REG_CROP_ROW_OFFSET: crop_row_offset <= cfg.data[pcmn_pkg::SIDE_W-1:0];
        pcmn_pkg::REG_CROP_COL_OFFSET: crop_col_offset <= cfg.data[pcmn_pkg::SIDE_W-1:0];
        pcmn_pkg::REG_MODE_FLAGS:      mode_flags      <= cfg.data[2:0];
        pcmn_pkg::REG_CHANNEL_MEANS:   channel_means   <= cfg.data;
        pcmn_pkg::REG_SCALE_FACTOR:    scale_factor    <= cfg.data[pcmn_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // crop side capped at the largest image side
  assign side = (crop_side > pcmn_pkg::SIZE_W'(pcmn_pkg::MAX_SIDE))
              ? pcmn_pkg::SIZE_W'(pcmn_pkg::MAX_SIDE) : crop_side;

  // window geometry: whole image when cropping is off
  always_comb begin
    geom.hgt      = pcmn_pkg::clamp_size(source_height);
    geom.wid      = pcmn_pkg::clamp_size(source_width);
    geom.mirror   = mode_flags[0];
    geom.mean_sel = pcmn_pkg::mean_src_t'(mode_flags[2:1]);
    if (side != '0) begin
      geom.oh = side;
      geom.ow = side;
      geom.r0 = crop_row_offset;
      geom.c0 = crop_col_offset;
    end else begin
      geom.oh = geom.hgt;
      geom.ow = geom.wid;
      geom.r0 = '0;
      geom.c0 = '0;
    end
  end

  // position tracking and classification
  pcmn_front u_front (
    .clk           (clk),
    .rst           (rst),
    .pixels        (pixels),
    .geom          (geom),
    .channel_means (channel_means),
    .full          (full),
    .push          (push),
    .push_entry    (push_entry)
  );

  // decoupling queue
  pcmn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  // index and value arithmetic, output register
  pcmn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .geom         (geom),
    .scale_factor (scale_factor),
    .results      (results)
  );

endmodule

### src/pcmn_front.sv
// ----------------------------------------------------------------------------
// pcmn_front: position tracking and window classification
// Accepts pixels, tracks channel/row/column, and pushes in-window pixels
// with their output coordinates and mean-subtracted difference.
// ----------------------------------------------------------------------------
module pcmn_front (
  input  logic                              clk,
  input  logic                              rst,
  pcmn_pix_if.sink                          pixels,
  input  pcmn_pkg::geom_t                   geom,
  input  logic [pcmn_pkg::MEANS_W-1:0]      channel_means,
  input  logic                              full,
  output logic                              push,
  output pcmn_pkg::entry_t                  push_entry
);

  logic [pcmn_pkg::CHAN_W-1:0] chan_count, chan_count_next;
  logic [pcmn_pkg::SIDE_W-1:0] row_count, row_count_next;
  logic [pcmn_pkg::SIDE_W-1:0] col_count, col_count_next;

  logic                        accept;
  logic [pcmn_pkg::CHAN_W-1:0] c;
  logic [pcmn_pkg::SIDE_W-1:0] r, k, h, w0, w;
  logic                        in_win;
  logic [pcmn_pkg::MEAN_W-1:0] mean;
  logic [pcmn_pkg::SIZE_W-1:0] k_inc, r_inc;

  assign pixels.ready = !full;
  assign accept = pixels.valid && pixels.ready;

  // start mark places this pixel at channel 0, row 0, column 0
  assign c = pixels.start_of_image ? '0 : chan_count;
  assign r = pixels.start_of_image ? '0 : row_count;
  assign k = pixels.start_of_image ? '0 : col_count;

  assign h  = r - geom.r0;
  assign w0 = k - geom.c0;
  assign in_win = (r >= geom.r0) && ({1'b0, h} < geom.oh) &&
                  (k >= geom.c0) && ({1'b0, w0} < geom.ow);
  assign w = geom.mirror ? pcmn_pkg::SIDE_W'(geom.ow - pcmn_pkg::SIZE_W'(1) - {1'b0, w0})
                         : w0;

  always_comb begin
    unique case (geom.mean_sel)
      pcmn_pkg::MEAN_CHANNEL: mean = channel_means[{c, 4'b0} +: pcmn_pkg::MEAN_W];
      pcmn_pkg::MEAN_STREAM:  mean = pixels.mean_sample;
      default:                mean = '0;
    endcase
  end

  assign push = accept && in_win;
  assign push_entry.chan = c;
  assign push_entry.h    = h;
  assign push_entry.w    = w;
  assign push_entry.diff = $signed({1'b0, pixels.pixel, 8'b0}) - $signed({1'b0, mean});

  // position advance: column, then row, then channel
  assign k_inc = {1'b0, k} + pcmn_pkg::SIZE_W'(1);
  assign r_inc = {1'b0, r} + pcmn_pkg::SIZE_W'(1);

  always_comb begin
    chan_count_next = c;
    row_count_next  = r;
    col_count_next  = k_inc[pcmn_pkg::SIDE_W-1:0];
    if (k_inc >= geom.wid) begin
      col_count_next = '0;
      row_count_next = r_inc[pcmn_pkg::SIDE_W-1:0];
      if (r_inc >= geom.hgt) begin
        row_count_next = '0;
        if (c == pcmn_pkg::CHAN_W'(pcmn_pkg::MAX_CHANNELS - 1)) chan_count_next = '0;
        else chan_count_next = c + pcmn_pkg::CHAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_count <= '0;
      row_count  <= '0;
      col_count  <= '0;
    end else if (accept) begin
      chan_count <= chan_count_next;
      row_count  <= row_count_next;
      col_count  <= col_count_next;
    end
  end

endmodule

### src/pcmn_queue.sv
// ----------------------------------------------------------------------------
// pcmn_queue: short queue between front and back
// Small register file with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module pcmn_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pcmn_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output pcmn_pkg::entry_t head
);

  pcmn_pkg::entry_t              mem [pcmn_pkg::QUEUE_DEPTH];
  logic [pcmn_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [pcmn_pkg::QCNT_W-1:0]   count;

  assign full       = (count == pcmn_pkg::QCNT_W'(pcmn_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + pcmn_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + pcmn_pkg::QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + pcmn_pkg::QCNT_W'(1);
        2'b01:   count <= count - pcmn_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // no overflow and no underflow
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");

endmodule

### src/pcmn_back.sv
// ----------------------------------------------------------------------------
// pcmn_back: index and value arithmetic
// Two stages: products (c * oh + h, diff * scale), then the row-major index
// and the rounded Q15.16 value into the output register.
// ----------------------------------------------------------------------------
module pcmn_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  pcmn_pkg::entry_t              head,
  output logic                          pop,
  input  pcmn_pkg::geom_t               geom,
  input  logic [pcmn_pkg::SCALE_W-1:0]  scale_factor,
  pcmn_res_if.source                    results
);

  logic                               s1_v;
  logic [pcmn_pkg::BASE_W-1:0]        s1_base;
  logic [pcmn_pkg::SIDE_W-1:0]        s1_w;
  logic signed [pcmn_pkg::PROD_W-1:0] s1_prod;

  logic                               out_v;
  logic [pcmn_pkg::IDX_W-1:0]         out_idx;
  logic signed [pcmn_pkg::VALUE_W-1:0] out_val;

  logic                               adv1, adv2;
  logic [pcmn_pkg::BASE_W-1:0]        base_c;
  logic signed [pcmn_pkg::PROD_W-1:0] prod_c;
  logic [pcmn_pkg::BASE_W+pcmn_pkg::SIZE_W-1:0] idx_c;
  logic signed [pcmn_pkg::PROD_W-1:0] rnd_c;

  assign adv2 = !out_v || results.ready;
  assign adv1 = !s1_v || adv2;
  assign pop  = head_valid && adv1;

  assign base_c = pcmn_pkg::BASE_W'(head.chan) * pcmn_pkg::BASE_W'(geom.oh)
                + pcmn_pkg::BASE_W'(head.h);
  assign prod_c = head.diff * $signed({1'b0, scale_factor});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv1) begin
      s1_v <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_base <= base_c;
      s1_w    <= head.w;
      s1_prod <= prod_c;
    end
  end

  assign idx_c = s1_base * pcmn_pkg::SIZE_W'(geom.ow)
               + (pcmn_pkg::BASE_W + pcmn_pkg::SIZE_W)'(s1_w);
  // round half up, floor shift; magnitude stays below 2^29 so it fits the output
  assign rnd_c = (s1_prod + pcmn_pkg::PROD_W'(128)) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv2) begin
      out_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      out_idx <= idx_c[pcmn_pkg::IDX_W-1:0];
      out_val <= rnd_c[pcmn_pkg::VALUE_W-1:0];
    end
  end

  assign results.valid      = out_v;
  assign results.dest_index = out_idx;
  assign results.value      = out_val;

  // a moving first stage always lands in the output register
  assert property (@(posedge clk) disable iff (rst) (s1_v && adv2) |=> out_v)
    else $error("item lost between back stages");
  assert property (@(posedge clk) disable iff (rst) (!s1_v && adv2) |=> !out_v)
    else $error("result invented in back stage");

endmodule

### sim/pixel_crop_mirror_normalize_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_crop_mirror_normalize_tb: self-checking bench for the crop stage
// Drives planar pixel items with random gaps and result back-pressure,
// tracks position, window, mirror and mean/scale math in a local predictor,
// and checks every result item in order against it.
// ----------------------------------------------------------------------------
module pixel_crop_mirror_normalize_tb;

  localparam int          WATCHDOG_LIMIT = 2000;  // cycles with nothing accepted
  localparam int          SETTLE_CYCLES  = 4;     // result latency plus margin
  localparam int unsigned ITEM_GOAL      = 1700;
  localparam int unsigned STEADY_ITEMS   = 160;   // tail of the run with no idling
  localparam logic [1:0]  MEAN_UNUSED    = 2'd3;  // spare mean code, acts as none
  localparam logic        MIRROR_ON      = 1'b1;
  localparam logic        MIRROR_OFF     = 1'b0;
  localparam longint      VALUE_MAX      = 64'sd2147483647;
  localparam longint      VALUE_MIN      = -64'sd2147483648;

  typedef struct packed {
    logic [pcmn_pkg::IDX_W-1:0]          dest_index;
    logic signed [pcmn_pkg::VALUE_W-1:0] value;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  pcmn_pix_if pix_ch ();
  pcmn_res_if res_ch ();
  pcmn_cfg_if cfg_ch ();

  pixel_crop_mirror_normalize dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  always #2 clk = ~clk;

  // shadow copy of the register bank, reset values
  logic [pcmn_pkg::SIZE_W-1:0]  sh_height    = pcmn_pkg::SIZE_W'(1);
  logic [pcmn_pkg::SIZE_W-1:0]  sh_width     = pcmn_pkg::SIZE_W'(1);
  logic [pcmn_pkg::SIZE_W-1:0]  sh_crop_side = '0;
  logic [pcmn_pkg::SIDE_W-1:0]  sh_row_off   = '0;
  logic [pcmn_pkg::SIDE_W-1:0]  sh_col_off   = '0;
  logic [2:0]                   sh_mode      = '0;
  logic [pcmn_pkg::MEANS_W-1:0] sh_means     = '0;
  logic [pcmn_pkg::SCALE_W-1:0] sh_scale     = pcmn_pkg::SCALE_W'(65536);

  // running position of the next pixel
  logic [pcmn_pkg::CHAN_W-1:0] chan_pos = '0;
  logic [pcmn_pkg::SIDE_W-1:0] row_pos  = '0;
  logic [pcmn_pkg::SIDE_W-1:0] col_pos  = '0;

  result_t     pending_results[$];
  result_t     oldest_result;
  int          fail_count   = 0;
  int          idle_cycles  = 0;
  int unsigned items_sent   = 0;
  int          stall_left   = 0;
  bit          gaps_allowed = 1'b1;  // sender may insert idle bursts
  bit          send_gaps    = 1'b1;  // per-image choice under gaps_allowed
  bit          stall_enable = 1'b1;  // receiver may drop ready

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  // size register into 1..MAX_SIDE
  function automatic int unsigned bounded_size(input logic [pcmn_pkg::SIZE_W-1:0] v);
    int unsigned n;
    n = v;
    if (n == 0) n = 1;
    else if (n > pcmn_pkg::MAX_SIDE) n = pcmn_pkg::MAX_SIDE;
    return n;
  endfunction

  // place one pixel, queue its result if it lands in the window, advance
  function automatic void predict_pixel(input logic [pcmn_pkg::PIXEL_W-1:0] pix,
                                        input logic [pcmn_pkg::MEAN_W-1:0] msamp,
                                        input logic sop);
    int unsigned hgt, wid, side, r0, c0, oh, ow, h, w, c, r, k;
    longint      diff, prod, q;
    logic [pcmn_pkg::MEAN_W-1:0] mean;
    pcmn_pkg::mean_src_t msel;
    result_t     res;
    hgt  = bounded_size(sh_height);
    wid  = bounded_size(sh_width);
    side = (sh_crop_side > pcmn_pkg::MAX_SIDE) ? pcmn_pkg::MAX_SIDE : sh_crop_side;
    // start mark puts this pixel at channel 0, row 0, column 0
    if (sop) begin
      chan_pos = '0;
      row_pos  = '0;
      col_pos  = '0;
    end
    c  = chan_pos;
    r  = row_pos;
    k  = col_pos;
    r0 = 0;
    c0 = 0;
    oh = hgt;
    ow = wid;
    if (side != 0) begin
      r0 = sh_row_off;
      c0 = sh_col_off;
      oh = side;
      ow = side;
    end
    // only pixels inside both image and window give a result, no padding
    if (r >= r0 && r - r0 < oh && k >= c0 && k - c0 < ow) begin
      h = r - r0;
      w = k - c0;
      if (sh_mode[0]) w = ow - 1 - w;
      res.dest_index = pcmn_pkg::IDX_W'((longint'(c) * oh + h) * ow + w);
      msel = pcmn_pkg::mean_src_t'(sh_mode[2:1]);
      mean = '0;
      if (msel == pcmn_pkg::MEAN_CHANNEL) begin
        mean = sh_means[c * pcmn_pkg::MEAN_W +: pcmn_pkg::MEAN_W];
      end else if (msel == pcmn_pkg::MEAN_STREAM) begin
        mean = msamp;
      end
      // pixel as q8.8 minus mean, times q4.16 scale, round half up to q15.16
      diff = longint'({pix, 8'h00}) - longint'(mean);
      prod = diff * longint'(sh_scale);
      q    = (prod + 128) >>> 8;
      if (q > VALUE_MAX) q = VALUE_MAX;
      else if (q < VALUE_MIN) q = VALUE_MIN;
      res.value = q[pcmn_pkg::VALUE_W-1:0];
      pending_results = {pending_results, res};
    end
    k++;
    if (k >= wid) begin
      k = 0;
      r++;
      if (r >= hgt) begin
        r = 0;
        c++;
        if (c >= pcmn_pkg::MAX_CHANNELS) c = 0;
      end
    end
    chan_pos = pcmn_pkg::CHAN_W'(c);
    row_pos  = pcmn_pkg::SIDE_W'(r);
    col_pos  = pcmn_pkg::SIDE_W'(k);
  endfunction

  // ------------------------------------------------------------------
  // result side: random back-pressure and in-order checking
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual index %0d value %0d",
                 $time, res_ch.dest_index, res_ch.value);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (res_ch.dest_index !== oldest_result.dest_index) begin
          $display("%0t: dest_index mismatch: expected %0d, actual %0d",
                   $time, oldest_result.dest_index, res_ch.dest_index);
          fail_count++;
        end
        if (res_ch.value !== oldest_result.value) begin
          $display("%0t: value mismatch: expected %0d, actual %0d",
                   $time, oldest_result.value, res_ch.value);
          fail_count++;
        end
      end
    end
    // random stall bursts on ready
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (!stall_enable) begin
      res_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // watchdog: no handshake on any channel for too long
  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_results.size());
      $display("pixel_crop_mirror_normalize verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // shared driving tasks
  // ------------------------------------------------------------------

  // one pixel item; may idle first, returns at the accepting edge
  task automatic send_pixel(input logic [pcmn_pkg::PIXEL_W-1:0] pix,
                            input logic [pcmn_pkg::MEAN_W-1:0] msamp,
                            input logic sop);
    if (gaps_allowed && send_gaps && $urandom_range(0, 5) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    pix_ch.valid          <= 1'b1;
    pix_ch.pixel          <= pix;
    pix_ch.mean_sample    <= msamp;
    pix_ch.start_of_image <= sop;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    predict_pixel(pix, msamp, sop);
    items_sent++;
  endtask

  task automatic stop_pixels();
    pix_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; valid stays up for the next write
  task automatic put_reg(input pcmn_pkg::cfg_reg_t which,
                         input logic [pcmn_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (which)
      pcmn_pkg::REG_SOURCE_HEIGHT:   sh_height    = data[pcmn_pkg::SIZE_W-1:0];
      pcmn_pkg::REG_SOURCE_WIDTH:    sh_width     = data[pcmn_pkg::SIZE_W-1:0];
      pcmn_pkg::REG_CROP_SIDE:       sh_crop_side = data[pcmn_pkg::SIZE_W-1:0];
      pcmn_pkg::REG_CROP_ROW_OFFSET: sh_row_off   = data[pcmn_pkg::SIDE_W-1:0];
      pcmn_pkg::REG_CROP_COL_OFFSET: sh_col_off   = data[pcmn_pkg::SIDE_W-1:0];
      pcmn_pkg::REG_MODE_FLAGS:      sh_mode      = data[2:0];
      pcmn_pkg::REG_CHANNEL_MEANS:   sh_means     = data;
      pcmn_pkg::REG_SCALE_FACTOR:    sh_scale     = data[pcmn_pkg::SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // full register set, only once the block has gone quiet
  task automatic set_config(input logic [pcmn_pkg::SIZE_W-1:0] height,
                            input logic [pcmn_pkg::SIZE_W-1:0] width,
                            input logic [pcmn_pkg::SIZE_W-1:0] side,
                            input logic [pcmn_pkg::SIDE_W-1:0] row_off,
                            input logic [pcmn_pkg::SIDE_W-1:0] col_off,
                            input logic [2:0] mode,
                            input logic [pcmn_pkg::MEANS_W-1:0] means,
                            input logic [pcmn_pkg::SCALE_W-1:0] scale);
    stop_pixels();
    wait_drained();
    put_reg(pcmn_pkg::REG_SOURCE_HEIGHT, height);
    put_reg(pcmn_pkg::REG_SOURCE_WIDTH, width);
    put_reg(pcmn_pkg::REG_CROP_SIDE, side);
    put_reg(pcmn_pkg::REG_CROP_ROW_OFFSET, row_off);
    put_reg(pcmn_pkg::REG_CROP_COL_OFFSET, col_off);
    put_reg(pcmn_pkg::REG_MODE_FLAGS, mode);
    put_reg(pcmn_pkg::REG_CHANNEL_MEANS, means);
    put_reg(pcmn_pkg::REG_SCALE_FACTOR, scale);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [pcmn_pkg::PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return pcmn_pkg::PIXEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [pcmn_pkg::MEAN_W-1:0] random_mean();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return pcmn_pkg::MEAN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly small sizes, now and then zero, the maximum or past it
  function automatic logic [pcmn_pkg::SIZE_W-1:0] random_size();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return pcmn_pkg::SIZE_W'(pcmn_pkg::MAX_SIDE);
      2:       return '1;
      default: return pcmn_pkg::SIZE_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [pcmn_pkg::SCALE_W-1:0] random_scale();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return pcmn_pkg::SCALE_W'(65536);
      default: return pcmn_pkg::SCALE_W'($urandom_range(0, 1048575));
    endcase
  endfunction

  task automatic random_config();
    logic [pcmn_pkg::SIZE_W-1:0] h, w, side;
    logic [pcmn_pkg::SIDE_W-1:0] ro, co;
    int unsigned                 span;
    h    = random_size();
    w    = random_size();
    span = (bounded_size(h) > bounded_size(w)) ? bounded_size(h) : bounded_size(w);
    if (span > 8) span = 8;
    side = ($urandom_range(0, 3) == 0) ? '0 : pcmn_pkg::SIZE_W'($urandom_range(1, span + 2));
    if ($urandom_range(0, 19) == 0) side = '1;
    ro   = ($urandom_range(0, 11) == 0) ? '1 : pcmn_pkg::SIDE_W'($urandom_range(0, 3));
    co   = ($urandom_range(0, 11) == 0) ? '1 : pcmn_pkg::SIDE_W'($urandom_range(0, 3));
    set_config(h, w, side, ro, co, 3'($urandom_range(0, 7)), {$urandom, $urandom},
               random_scale());
    stall_enable = ($urandom_range(0, 3) != 0);
  endtask

  // one planar image, now and then truncated, unmarked or marked mid-way
  task automatic send_image();
    int unsigned len;
    logic        sop;
    len = bounded_size(sh_height) * bounded_size(sh_width) *
          $urandom_range(1, pcmn_pkg::MAX_CHANNELS);
    if (len > 300) len = $urandom_range(20, 80);
    if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
    send_gaps = ($urandom_range(0, 3) != 0);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == 0) sop = ($urandom_range(0, 9) != 0);
      else sop = ($urandom_range(0, 59) == 0);
      send_pixel(random_pixel(), random_mean(), sop);
    end
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // registers at reset: 1x1 image, so each item moves to the next channel
  task automatic test_reset_state();
    send_pixel(8'h00, 16'hFFFF, 1'b1);
    send_pixel(8'hFF, 16'h0000, 1'b0);
    send_pixel(8'h80, 16'h1234, 1'b1);  // start mark back to channel 0
    send_pixel(8'h7F, 16'hABCD, 1'b0);
    stop_pixels();
  endtask

  // every mode code on a 1x1 image, with extreme means and scales
  task automatic test_mode_codes();
    logic [pcmn_pkg::SCALE_W-1:0] scale;
    for (int m = 0; m < 8; m++) begin
      case (m % 4)
        0:       scale = '0;
        1:       scale = '1;
        2:       scale = pcmn_pkg::SCALE_W'(1);
        default: scale = pcmn_pkg::SCALE_W'(65536);
      endcase
      set_config(pcmn_pkg::SIZE_W'(1), pcmn_pkg::SIZE_W'(1), '0, '0, '0, 3'(m),
                 (m < 4) ? '1 : 64'h0123_FF00_8000_00FF, scale);
      send_pixel((m % 2 == 0) ? 8'hFF : 8'h00, (m < 4) ? 16'hFFFF : 16'h0001, 1'b1);
    end
    stop_pixels();
  endtask

  // zero and oversized sizes, full-size crop, window past the image
  task automatic test_geometry();
    // zero height and width act as 1
    set_config('0, '0, '0, '0, '0, {pcmn_pkg::MEAN_CHANNEL, MIRROR_ON},
               64'hFFFF_0000_8000_0001, '1);
    send_pixel(8'h10, 16'h0000, 1'b1);
    send_pixel(8'hFF, 16'h0000, 1'b0);
    // crop side past the maximum, mirrored: indexes reach the top bits
    set_config(pcmn_pkg::SIZE_W'(2), pcmn_pkg::SIZE_W'(2), '1, '0, '0,
               {pcmn_pkg::MEAN_STREAM, MIRROR_ON}, '0, pcmn_pkg::SCALE_W'(65536));
    for (int i = 0; i < 10; i++) send_pixel(random_pixel(), random_mean(), i == 0);
    // window beyond the image edge, spare mean code: nothing comes out
    set_config(pcmn_pkg::SIZE_W'(pcmn_pkg::MAX_SIDE), pcmn_pkg::SIZE_W'(pcmn_pkg::MAX_SIDE),
               pcmn_pkg::SIZE_W'(pcmn_pkg::MAX_SIDE), '1, '1,
               {MEAN_UNUSED, MIRROR_OFF}, '1, pcmn_pkg::SCALE_W'(1));
    send_pixel(8'hAA, 16'h5555, 1'b1);
    send_pixel(8'h55, 16'hAAAA, 1'b0);
    send_pixel(8'hFF, 16'hFFFF, 1'b0);
    stop_pixels();
  endtask

  // sender holds off mid-image until every result is back
  task automatic test_sender_pause();
    set_config(pcmn_pkg::SIZE_W'(3), pcmn_pkg::SIZE_W'(4), pcmn_pkg::SIZE_W'(2),
               pcmn_pkg::SIDE_W'(1), pcmn_pkg::SIDE_W'(1),
               {pcmn_pkg::MEAN_STREAM, MIRROR_ON}, {$urandom, $urandom},
               pcmn_pkg::SCALE_W'(20'h18000));
    send_gaps = 1'b1;
    for (int i = 0; i < 30; i++) send_pixel(random_pixel(), random_mean(), i == 0);
    stop_pixels();
    while (pending_results.size() != 0) @(posedge clk);
    for (int i = 0; i < 30; i++) send_pixel(random_pixel(), random_mean(), 1'b0);
    stop_pixels();
  endtask

  // random configurations, each followed by a few images
  task automatic test_random_images(input int unsigned item_goal);
    while (items_sent < item_goal) begin
      random_config();
      repeat ($urandom_range(2, 5)) begin
        if (items_sent < item_goal) send_image();
      end
    end
    stop_pixels();
  endtask

  // back-to-back items with the receiver always ready
  task automatic test_steady_stream(input int unsigned item_goal);
    set_config(pcmn_pkg::SIZE_W'(5), pcmn_pkg::SIZE_W'(6), pcmn_pkg::SIZE_W'(4),
               pcmn_pkg::SIDE_W'(1), pcmn_pkg::SIDE_W'(1),
               {pcmn_pkg::MEAN_CHANNEL, MIRROR_ON}, {$urandom, $urandom}, random_scale());
    gaps_allowed = 1'b0;
    stall_enable = 1'b0;
    while (items_sent < item_goal) send_image();
    stop_pixels();
  endtask

  initial begin
    rst                   <= 1'b1;
    pix_ch.valid          <= 1'b0;
    pix_ch.pixel          <= '0;
    pix_ch.mean_sample    <= '0;
    pix_ch.start_of_image <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= pcmn_pkg::REG_SOURCE_HEIGHT;
    cfg_ch.data           <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_mode_codes();
    test_geometry();
    test_sender_pause();
    test_random_images(ITEM_GOAL - STEADY_ITEMS);
    // the steady tail always runs, even when the random part overshoots
    test_steady_stream(items_sent + STEADY_ITEMS);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("pixel_crop_mirror_normalize verification clean");
    end else begin
      $display("pixel_crop_mirror_normalize verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/pcmn_pkg.sv
src/pcmn_if.sv
src/pcmn_front.sv
src/pcmn_queue.sv
src/pcmn_back.sv
src/pixel_crop_mirror_normalize.sv
sim/pixel_crop_mirror_normalize_tb.sv
